// ===== rtl/core/tcc_pkg.sv =====
// Package for the text console cell store: field widths, command and
// register codes, character constants, sequencer states and the command plan.
// No dependencies; the console store, the cursor unit and the bench import it.
`timescale 1ns / 1ps

package tcc_pkg;

    localparam int COL_W     = 7;
    localparam int LINE_W    = 6;
    localparam int CHAR_W    = 8;
    localparam int ATTR_W    = 8;
    localparam int CELL_W    = CHAR_W + ATTR_W;
    localparam int CMD_W     = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 8;
    localparam int COLS_W    = 8;
    localparam int ROWS_W    = 7;

    // Effective column / row counts, wide enough for the largest store size
    // (256 columns, 128 rows) plus one.
    localparam int ECOL_W = 9;
    localparam int EROW_W = 8;

    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_RETURN  = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_BACK    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;

    localparam logic [COLS_W-1:0] RESET_COLUMNS = 8'd80;
    localparam logic [ROWS_W-1:0] RESET_ROWS    = 7'd30;
    localparam logic [ATTR_W-1:0] RESET_ATTR    = 8'h07;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT        = 3'd0,
        CMD_ERASE      = 3'd1,
        CMD_WRITE_AT   = 3'd2,
        CMD_SET_CURSOR = 3'd3,
        CMD_CLEAR      = 3'd4,
        CMD_READ       = 3'd5
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COLUMNS = 2'd0,
        CFG_ROWS    = 2'd1,
        CFG_ATTR    = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_FILL,
        ST_IDLE,
        ST_CMD,
        ST_SCROLL,
        ST_BLANK,
        ST_READ,
        ST_RESP
    } state_t;

    // What one command does to the cursor and the store.
    typedef struct packed {
        logic [COL_W-1:0]  new_col;
        logic [LINE_W-1:0] new_row;
        logic              wr_en;
        logic [COL_W-1:0]  wr_col;
        logic [LINE_W-1:0] wr_row;
        logic [CHAR_W-1:0] wr_char;
        logic              do_scroll;
        logic              do_clear;
    } plan_t;

endpackage

// ===== rtl/core/text_console_cursor_and_cell_store.sv =====
// Text console cursor and cell store. An accepted command passes through the
// decode, read and result states, with the result strobe in the last; a scroll
// adds a row copy through the RAM, then one blank write per column, or just
// the blank writes with a single usable row, and clear adds one RAM write per
// cell of the whole store. The single RAM write port paces both.
// After reset the store is swept to blanks with busy high; the receiver cannot
// stall.
`timescale 1ns / 1ps

module text_console_cursor_and_cell_store #(
    parameter int MAX_COLUMNS = 128,
    parameter int MAX_LINES   = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // command channel
    input  logic                          start,
    output logic                          busy,
    input  logic [tcc_pkg::CMD_W-1:0]     cmd,
    input  logic [tcc_pkg::CHAR_W-1:0]    char_code,
    input  logic [tcc_pkg::COL_W-1:0]     column,
    input  logic [tcc_pkg::LINE_W-1:0]    line,
    // result channel
    output logic                          done,
    output logic [tcc_pkg::COL_W-1:0]     cursor_column,
    output logic [tcc_pkg::LINE_W-1:0]    cursor_line,
    output logic [tcc_pkg::CHAR_W-1:0]    cell_char,
    output logic [tcc_pkg::ATTR_W-1:0]    cell_attr,
    output logic                          scrolled,
    // configuration write port
    input  logic                          cfg_we,
    input  logic [tcc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tcc_pkg::CFG_W-1:0]     cfg_data
);

    import tcc_pkg::*;

    localparam int DEPTH = MAX_COLUMNS * MAX_LINES;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(MAX_COLUMNS);
    localparam int RW    = $clog2(MAX_LINES);

    localparam logic [AW-1:0]     FILL_LAST  = AW'(DEPTH - 1);
    localparam logic [AW-1:0]     ROW_STRIDE = AW'(MAX_COLUMNS);
    localparam logic [ECOL_W-1:0] COLS_MAX   = ECOL_W'(MAX_COLUMNS);
    localparam logic [EROW_W-1:0] ROWS_MAX   = EROW_W'(MAX_LINES);

    // ---------------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------------
    state_t            state_reg, state_next;
    logic [COLS_W-1:0] cols_reg;
    logic [ROWS_W-1:0] rows_reg;
    logic [ATTR_W-1:0] attr_reg;

    logic [COL_W-1:0]  cur_col_reg, cur_col_next;
    logic [LINE_W-1:0] cur_row_reg, cur_row_next;

    // latched command beat
    cmd_t              cmd_reg;
    logic [CHAR_W-1:0] char_reg;
    logic [COL_W-1:0]  col_reg;
    logic [LINE_W-1:0] line_reg;

    logic [AW-1:0]     fill_addr_reg, fill_addr_next;
    logic              fill_cmd_reg, fill_cmd_next;
    logic [RW-1:0]     scr_row_reg, scr_row_next;
    logic [XW-1:0]     scr_col_reg, scr_col_next;
    logic              cp_pend_reg, cp_pend_next;
    logic [AW-1:0]     cp_addr_reg, cp_addr_next;
    logic              scrolled_reg, scrolled_next;
    logic              rd_oob_reg, rd_oob_next;

    // ---------------------------------------------------------------------
    // Effective geometry: zero acts as one, above the store acts as the max
    // ---------------------------------------------------------------------
    logic [ECOL_W-1:0] eff_cols;
    logic [EROW_W-1:0] eff_rows;
    logic [XW-1:0]     last_col;
    logic [RW-1:0]     last_row;

    always_comb
    begin
        if (cols_reg == '0)
            eff_cols = ECOL_W'(1);
        else if (ECOL_W'(cols_reg) > COLS_MAX)
            eff_cols = COLS_MAX;
        else
            eff_cols = ECOL_W'(cols_reg);

        if (rows_reg == '0)
            eff_rows = EROW_W'(1);
        else if (EROW_W'(rows_reg) > ROWS_MAX)
            eff_rows = ROWS_MAX;
        else
            eff_rows = EROW_W'(rows_reg);

        last_col = XW'(eff_cols - ECOL_W'(1));
        last_row = RW'(eff_rows - EROW_W'(1));
    end

    function automatic logic [AW-1:0] cell_addr(input logic [EROW_W-1:0] r,
                                                input logic [ECOL_W-1:0] c);
        cell_addr = AW'(r) * ROW_STRIDE + AW'(c);
    endfunction

    // ---------------------------------------------------------------------
    // Command decode
    // ---------------------------------------------------------------------
    plan_t plan;

    tcc_cursor_unit u_cursor (
        .cmd       (cmd_reg),
        .char_code (char_reg),
        .column    (col_reg),
        .line      (line_reg),
        .cur_col   (cur_col_reg),
        .cur_row   (cur_row_reg),
        .eff_cols  (eff_cols),
        .eff_rows  (eff_rows),
        .plan      (plan)
    );

    // ---------------------------------------------------------------------
    // Cell store
    // ---------------------------------------------------------------------
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [CELL_W-1:0] ram_rdata;

    tcc_ram #(
        .WIDTH (CELL_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Read position of the result: the target of a read command, else the
    // cursor after the command. Outside the store reads as zero.
    logic [ECOL_W-1:0] rd_col_x;
    logic [EROW_W-1:0] rd_row_x;
    logic              rd_oob;

    always_comb
    begin
        if (cmd_reg == CMD_READ)
        begin
            rd_col_x = ECOL_W'(col_reg);
            rd_row_x = EROW_W'(line_reg);
        end
        else
        begin
            rd_col_x = ECOL_W'(cur_col_reg);
            rd_row_x = EROW_W'(cur_row_reg);
        end
        rd_oob = (rd_col_x >= COLS_MAX) || (rd_row_x >= ROWS_MAX);
    end

    // ---------------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_FILL:
            begin
                if (fill_addr_reg == FILL_LAST)
                    state_next = fill_cmd_reg ? ST_READ : ST_IDLE;
            end
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_CMD;
            end
            ST_CMD:
            begin
                if (plan.do_clear)
                    state_next = ST_FILL;
                else if (plan.do_scroll)
                    state_next = (eff_rows > EROW_W'(1)) ? ST_SCROLL : ST_BLANK;
                else
                    state_next = ST_READ;
            end
            ST_SCROLL:
            begin
                if (scr_col_reg == last_col && scr_row_reg == last_row)
                    state_next = ST_BLANK;
            end
            ST_BLANK:
            begin
                if (!cp_pend_reg && scr_col_reg == last_col)
                    state_next = ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // Datapath control: counters, cursor, store ports
    // ---------------------------------------------------------------------
    always_comb
    begin
        cur_col_next   = cur_col_reg;
        cur_row_next   = cur_row_reg;
        fill_addr_next = fill_addr_reg;
        fill_cmd_next  = fill_cmd_reg;
        scr_row_next   = scr_row_reg;
        scr_col_next   = scr_col_reg;
        scrolled_next  = scrolled_reg;
        rd_oob_next    = rd_oob_reg;
        // a copy read issued now lands one row up next cycle
        cp_pend_next   = (state_reg == ST_SCROLL);
        cp_addr_next   = cell_addr(EROW_W'(scr_row_reg - RW'(1)), ECOL_W'(scr_col_reg));

        ram_we    = 1'b0;
        ram_waddr = cp_addr_reg;
        ram_wdata = ram_rdata;
        ram_re    = 1'b0;
        ram_raddr = cell_addr(EROW_W'(scr_row_reg), ECOL_W'(scr_col_reg));

        // drain the pending copy write first; it owns the write port
        if (cp_pend_reg)
        begin
            ram_we = 1'b1;
        end

        case (state_reg)
            ST_FILL:
            begin
                ram_we         = 1'b1;
                ram_waddr      = fill_addr_reg;
                ram_wdata      = {fill_cmd_reg ? attr_reg : RESET_ATTR, CH_SPACE};
                fill_addr_next = fill_addr_reg + AW'(1);
            end
            ST_CMD:
            begin
                ram_we        = plan.wr_en;
                ram_waddr     = cell_addr(EROW_W'(plan.wr_row), ECOL_W'(plan.wr_col));
                ram_wdata     = {attr_reg, plan.wr_char};
                cur_col_next  = plan.new_col;
                cur_row_next  = plan.new_row;
                scrolled_next = plan.do_scroll;
                scr_row_next  = RW'(1);
                scr_col_next  = '0;
                if (plan.do_clear)
                begin
                    fill_addr_next = '0;
                    fill_cmd_next  = 1'b1;
                end
            end
            ST_SCROLL:
            begin
                ram_re = 1'b1;
                if (scr_col_reg == last_col)
                begin
                    scr_col_next = '0;
                    scr_row_next = scr_row_reg + RW'(1);
                end
                else
                begin
                    scr_col_next = scr_col_reg + XW'(1);
                end
            end
            ST_BLANK:
            begin
                if (!cp_pend_reg)
                begin
                    ram_we       = 1'b1;
                    ram_waddr    = cell_addr(EROW_W'(last_row), ECOL_W'(scr_col_reg));
                    ram_wdata    = {attr_reg, CH_SPACE};
                    scr_col_next = scr_col_reg + XW'(1);
                end
            end
            ST_READ:
            begin
                ram_re      = !rd_oob;
                ram_raddr   = cell_addr(rd_row_x, rd_col_x);
                rd_oob_next = rd_oob;
            end
            default:
            begin
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FILL;
            cur_col_reg   <= '0;
            cur_row_reg   <= '0;
            fill_addr_reg <= '0;
            fill_cmd_reg  <= 1'b0;
            scr_row_reg   <= '0;
            scr_col_reg   <= '0;
            cp_pend_reg   <= 1'b0;
            scrolled_reg  <= 1'b0;
            rd_oob_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_col_reg   <= cur_col_next;
            cur_row_reg   <= cur_row_next;
            fill_addr_reg <= fill_addr_next;
            fill_cmd_reg  <= fill_cmd_next;
            scr_row_reg   <= scr_row_next;
            scr_col_reg   <= scr_col_next;
            cp_pend_reg   <= cp_pend_next;
            scrolled_reg  <= scrolled_next;
            rd_oob_reg    <= rd_oob_next;
        end
    end

    // configuration registers; user rule: written only while idle, not enforced
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= RESET_COLUMNS;
            rows_reg <= RESET_ROWS;
            attr_reg <= RESET_ATTR;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_COLUMNS: cols_reg <= COLS_W'(cfg_data);
                CFG_ROWS:    rows_reg <= ROWS_W'(cfg_data);
                CFG_ATTR:    attr_reg <= ATTR_W'(cfg_data);
                default:
                begin
                end
            endcase
        end
    end

    // payload: hold the command beat and the copy address
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            cmd_reg  <= cmd_t'(cmd);
            char_reg <= char_code;
            col_reg  <= column;
            line_reg <= line;
        end
        cp_addr_reg <= cp_addr_next;
    end

    // ---------------------------------------------------------------------
    // Ports
    // ---------------------------------------------------------------------
    assign busy          = (state_reg != ST_IDLE);
    assign done          = (state_reg == ST_RESP);
    assign cursor_column = cur_col_reg;
    assign cursor_line   = cur_row_reg;
    assign cell_char     = rd_oob_reg ? '0 : ram_rdata[CHAR_W-1:0];
    assign cell_attr     = rd_oob_reg ? '0 : ram_rdata[CELL_W-1:CHAR_W];
    assign scrolled      = scrolled_reg;

`ifndef NO_ASSERTIONS
    // an accepted beat always enters command decode next cycle
    a_accept_to_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == ST_CMD))
        else $error("accepted beat did not enter decode");

    // a copy write never outlives the scroll and blank phases
    a_copy_scope: assert property (@(posedge clk) disable iff (!rst_n)
        cp_pend_reg |-> (state_reg == ST_SCROLL || state_reg == ST_BLANK))
        else $error("copy write pending outside scroll");

    // the result read never races a write still in flight
    a_read_after_writes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> (!cp_pend_reg && !ram_we))
        else $error("result read overlaps a store write");

    // no read and write of the same cell in one cycle
    a_no_same_cell: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("read and write hit the same cell");

    // a scroll is only ever run for a command that reports it
    a_scroll_flagged: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCROLL || state_reg == ST_BLANK) |-> scrolled_reg)
        else $error("scroll without scrolled flag");
`endif

endmodule

// ===== rtl/core/tcc_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
`timescale 1ns / 1ps

module tcc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8192,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/tcc_cursor_unit.sv =====
// Command decode for the text console: next cursor, the single cell write of
// a command, and scroll / clear requests. Depends on tcc_pkg.
`timescale 1ns / 1ps

module tcc_cursor_unit (
    input  logic [tcc_pkg::CMD_W-1:0]  cmd,
    input  logic [tcc_pkg::CHAR_W-1:0] char_code,
    input  logic [tcc_pkg::COL_W-1:0]  column,
    input  logic [tcc_pkg::LINE_W-1:0] line,
    input  logic [tcc_pkg::COL_W-1:0]  cur_col,
    input  logic [tcc_pkg::LINE_W-1:0] cur_row,
    input  logic [tcc_pkg::ECOL_W-1:0] eff_cols,
    input  logic [tcc_pkg::EROW_W-1:0] eff_rows,
    output tcc_pkg::plan_t             plan
);

    import tcc_pkg::*;

    logic [ECOL_W-1:0] col_x;
    logic [EROW_W-1:0] row_x;
    logic [COL_W-1:0]  last_col;
    logic [LINE_W-1:0] last_row;
    logic              wr_req;
    logic              step;
    logic [EROW_W-1:0] step_row;
    logic              moved;

    always_comb
    begin
        col_x    = ECOL_W'(cur_col);
        row_x    = EROW_W'(cur_row);
        last_col = COL_W'(eff_cols - ECOL_W'(1));
        last_row = LINE_W'(eff_rows - EROW_W'(1));

        plan         = '0;
        plan.new_col = cur_col;
        plan.new_row = cur_row;
        plan.wr_col  = cur_col;
        plan.wr_row  = cur_row;
        plan.wr_char = char_code;
        wr_req       = 1'b0;
        step         = 1'b0;
        step_row     = row_x;

        // step back one cell, crossing to the row above; stay at the origin
        moved = 1'b1;
        if (cur_col != '0)
        begin
            plan.new_col = cur_col - COL_W'(1);
        end
        else if (cur_row != '0)
        begin
            plan.new_col = last_col;
            plan.new_row = cur_row - LINE_W'(1);
        end
        else
        begin
            moved = 1'b0;
        end

        case (cmd_t'(cmd))
            CMD_PUT:
            begin
                if (char_code != CH_BACK)
                begin
                    plan.new_col = cur_col;
                    plan.new_row = cur_row;
                end
                case (char_code)
                    CH_NEWLINE:
                    begin
                        plan.new_col = '0;
                        step         = 1'b1;
                        step_row     = row_x + EROW_W'(1);
                    end
                    CH_RETURN:
                    begin
                        plan.new_col = '0;
                    end
                    CH_BACK:
                    begin
                    end
                    default:
                    begin
                        wr_req = 1'b1;
                        step   = 1'b1;
                        if (col_x + ECOL_W'(1) >= eff_cols)
                        begin
                            plan.new_col = '0;
                            step_row     = row_x + EROW_W'(1);
                        end
                        else
                        begin
                            plan.new_col = cur_col + COL_W'(1);
                        end
                    end
                endcase
            end
            CMD_ERASE:
            begin
                wr_req       = moved;
                plan.wr_col  = plan.new_col;
                plan.wr_row  = plan.new_row;
                plan.wr_char = CH_SPACE;
            end
            CMD_WRITE_AT:
            begin
                plan.new_col = cur_col;
                plan.new_row = cur_row;
                wr_req       = 1'b1;
                plan.wr_col  = column;
                plan.wr_row  = line;
            end
            CMD_SET_CURSOR:
            begin
                plan.new_col = (ECOL_W'(column) >= eff_cols) ? last_col : column;
                plan.new_row = (EROW_W'(line) >= eff_rows) ? last_row : line;
            end
            CMD_CLEAR:
            begin
                plan.new_col  = '0;
                plan.new_row  = '0;
                plan.do_clear = 1'b1;
            end
            default:
            begin
                plan.new_col = cur_col;
                plan.new_row = cur_row;
            end
        endcase

        // row step: past the last usable row scrolls and pins to that row
        if (step)
        begin
            if (step_row >= eff_rows)
            begin
                plan.do_scroll = 1'b1;
                plan.new_row   = last_row;
            end
            else
            begin
                plan.new_row = LINE_W'(step_row);
            end
        end

        plan.wr_en = wr_req && (ECOL_W'(plan.wr_col) < eff_cols)
                     && (EROW_W'(plan.wr_row) < eff_rows);
    end

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the text console cursor and cell store.
// Drives directed and random console commands, predicts each result beat
// with an in-bench screen model. Depends on tcc_pkg and the console RTL.
`timescale 1ns / 1ps

module tb_top;

    import tcc_pkg::*;

    localparam int STORE_COLS  = 128;
    localparam int STORE_ROWS  = 64;
    localparam int STALL_LIMIT = 40000;  // a few times the longest clear, fill or scroll
    localparam int TAIL_CYCLES = 16;

    // Command codes the block leaves unused; they must change nothing.
    localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [LINE_W-1:0] row;
        logic [CHAR_W-1:0] ch;
        logic [ATTR_W-1:0] attr;
        logic              scrolled;
    } console_view_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [CMD_W-1:0]     cmd = '0;
    logic [CHAR_W-1:0]    char_code = '0;
    logic [COL_W-1:0]     column = '0;
    logic [LINE_W-1:0]    line = '0;
    logic                 done;
    logic [COL_W-1:0]     cursor_column;
    logic [LINE_W-1:0]    cursor_line;
    logic [CHAR_W-1:0]    cell_char;
    logic [ATTR_W-1:0]    cell_attr;
    logic                 scrolled;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    // Screen model: cells hold {attribute, character}, row-major at full width.
    logic [CELL_W-1:0]    screen [STORE_COLS*STORE_ROWS];
    logic [COL_W-1:0]     cur_col;
    logic [LINE_W-1:0]    cur_row;
    logic [COLS_W-1:0]    cfg_columns = RESET_COLUMNS;
    logic [ROWS_W-1:0]    cfg_rows = RESET_ROWS;
    logic [ATTR_W-1:0]    cfg_attr = RESET_ATTR;

    console_view_t        views_due [$];
    int                   error_count = 0;
    int                   quiet_cycles = 0;
    int                   gap_max = 7;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    text_console_cursor_and_cell_store DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .char_code     (char_code),
        .column        (column),
        .line          (line),
        .done          (done),
        .cursor_column (cursor_column),
        .cursor_line   (cursor_line),
        .cell_char     (cell_char),
        .cell_attr     (cell_attr),
        .scrolled      (scrolled),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // ------------------------------------------------------------------
    // Screen model
    // ------------------------------------------------------------------

    // Zero acts as one, anything past the store acts as the store size.
    function automatic int usable_cols();
        if (cfg_columns == 0)
            return 1;
        if (cfg_columns > STORE_COLS)
            return STORE_COLS;
        return int'(cfg_columns);
    endfunction

    function automatic int usable_rows();
        if (cfg_rows == 0)
            return 1;
        if (cfg_rows > STORE_ROWS)
            return STORE_ROWS;
        return int'(cfg_rows);
    endfunction

    function automatic logic [CELL_W-1:0] blank_cell();
        return {cfg_attr, CH_SPACE};
    endfunction

    // Blank the whole store (not just the usable area) and home the cursor.
    function automatic void blank_screen();
        int i;
        for (i = 0; i < STORE_COLS * STORE_ROWS; i++)
            screen[i] = blank_cell();
        cur_col = '0;
        cur_row = '0;
    endfunction

    // Drop writes that land outside the usable area.
    function automatic void put_cell(int x, int y, logic [CHAR_W-1:0] ch);
        if (x >= usable_cols() || y >= usable_rows())
            return;
        screen[y * STORE_COLS + x] = {cfg_attr, ch};
    endfunction

    function automatic void scroll_screen();
        int nc;
        int nr;
        int x;
        int y;
        nc = usable_cols();
        nr = usable_rows();
        for (y = 0; y + 1 < nr; y++)
            for (x = 0; x < nc; x++)
                screen[y * STORE_COLS + x] = screen[(y + 1) * STORE_COLS + x];
        for (x = 0; x < nc; x++)
            screen[(nr - 1) * STORE_COLS + x] = blank_cell();
    endfunction

    // Move to the given row; scroll and pin to the last row when it runs off.
    function automatic bit advance_row(int row);
        if (row >= usable_rows())
        begin
            scroll_screen();
            cur_row = LINE_W'(usable_rows() - 1);
            return 1'b1;
        end
        cur_row = LINE_W'(row);
        return 1'b0;
    endfunction

    // Step back one cell, across a row boundary; hold at the origin.
    function automatic bit step_back();
        if (cur_col > 0)
        begin
            cur_col = cur_col - COL_W'(1);
            return 1'b1;
        end
        if (cur_row > 0)
        begin
            cur_col = COL_W'(usable_cols() - 1);
            cur_row = cur_row - LINE_W'(1);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Apply one accepted command to the model and queue the view it reports.
    function automatic void predict_console(logic [CMD_W-1:0] op, logic [CHAR_W-1:0] ch,
                                            logic [COL_W-1:0] col, logic [LINE_W-1:0] ln);
        console_view_t     view;
        bit                moved_up;
        logic [CELL_W-1:0] shown;
        moved_up = 1'b0;
        case (op)
            CMD_PUT:
            begin
                if (ch == CH_NEWLINE)
                begin
                    cur_col = '0;
                    moved_up = advance_row(int'(cur_row) + 1);
                end
                else if (ch == CH_RETURN)
                    cur_col = '0;
                else if (ch == CH_BACK)
                    void'(step_back());
                else
                begin
                    // Everything else prints, NUL included, then the cursor advances.
                    put_cell(int'(cur_col), int'(cur_row), ch);
                    if (int'(cur_col) + 1 >= usable_cols())
                    begin
                        cur_col = '0;
                        moved_up = advance_row(int'(cur_row) + 1);
                    end
                    else
                    begin
                        cur_col = cur_col + COL_W'(1);
                        moved_up = advance_row(int'(cur_row));
                    end
                end
            end
            CMD_ERASE:
            begin
                if (step_back())
                    put_cell(int'(cur_col), int'(cur_row), CH_SPACE);
            end
            CMD_WRITE_AT:
                put_cell(int'(col), int'(ln), ch);
            CMD_SET_CURSOR:
            begin
                cur_col = COL_W'((int'(col) >= usable_cols()) ? usable_cols() - 1 : int'(col));
                cur_row = LINE_W'((int'(ln) >= usable_rows()) ? usable_rows() - 1 : int'(ln));
            end
            CMD_CLEAR:
                blank_screen();
            default:
                ;
        endcase
        if (op == CMD_READ)
            shown = screen[int'(ln) * STORE_COLS + int'(col)];
        else
            shown = screen[int'(cur_row) * STORE_COLS + int'(cur_col)];
        view.col      = cur_col;
        view.row      = cur_row;
        view.ch       = shown[CHAR_W-1:0];
        view.attr     = shown[CELL_W-1:CHAR_W];
        view.scrolled = moved_up;
        views_due.push_back(view);
    endfunction

    // ------------------------------------------------------------------
    // Result checking: every done beat must match the oldest view due
    // ------------------------------------------------------------------

    function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        console_view_t want;
        if (rst_n && done)
        begin
            if (views_due.size() == 0)
            begin
                $error("result beat with no command outstanding");
                error_count++;
            end
            else
            begin
                want = views_due.pop_front();
                compare_field("cursor_column", 8'(want.col), 8'(cursor_column));
                compare_field("cursor_line", 8'(want.row), 8'(cursor_line));
                compare_field("cell_char", want.ch, cell_char);
                compare_field("cell_attr", want.attr, cell_attr);
                compare_field("scrolled", 8'(want.scrolled), 8'(scrolled));
            end
        end
    end

    // Count cycles in which no beat moves on any port; any progress resets it.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : watchdog
        do
            @(posedge clk);
        while (quiet_cycles < STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------

    // Send one command beat. Start stays high on return so a back-to-back
    // beat can follow with no gap; drop it only when a gap is drawn.
    task automatic send_command(logic [CMD_W-1:0] op, logic [CHAR_W-1:0] ch,
                                logic [COL_W-1:0] col, logic [LINE_W-1:0] ln);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        cmd       <= op;
        char_code <= ch;
        column    <= col;
        line      <= ln;
        do
            @(posedge clk);
        while (busy);
        predict_console(op, ch, col, ln);
    endtask

    // Hold off until every result beat is in and the block is idle.
    task automatic drain();
        start <= 1'b0;
        while (views_due.size() != 0 || busy)
            @(posedge clk);
    endtask

    // Write all three registers, one per cycle, with the block idle.
    task automatic set_geometry(logic [CFG_W-1:0] cols, logic [CFG_W-1:0] rows,
                                logic [CFG_W-1:0] attr);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_COLUMNS;
        cfg_data  <= cols;
        @(posedge clk);
        cfg_columns = cols;
        cfg_index <= CFG_ROWS;
        cfg_data  <= rows;
        @(posedge clk);
        cfg_rows = rows[ROWS_W-1:0];
        cfg_index <= CFG_ATTR;
        cfg_data  <= attr;
        @(posedge clk);
        cfg_attr = attr;
        cfg_we <= 1'b0;
    endtask

    // Mostly aim inside the usable area or just past its edge; now and then
    // anywhere in the field so every bit toggles.
    function automatic logic [COL_W-1:0] pick_column();
        int hi;
        if ($urandom_range(0, 3) == 0)
            return COL_W'($urandom_range(0, STORE_COLS - 1));
        hi = usable_cols() + 1;
        if (hi > STORE_COLS - 1)
            hi = STORE_COLS - 1;
        return COL_W'($urandom_range(0, hi));
    endfunction

    function automatic logic [LINE_W-1:0] pick_line();
        int hi;
        if ($urandom_range(0, 3) == 0)
            return LINE_W'($urandom_range(0, STORE_ROWS - 1));
        hi = usable_rows() + 1;
        if (hi > STORE_ROWS - 1)
            hi = STORE_ROWS - 1;
        return LINE_W'($urandom_range(0, hi));
    endfunction

    // Printed text is mostly plain bytes with line control mixed in.
    function automatic logic [CHAR_W-1:0] pick_char();
        case ($urandom_range(0, 9))
            0: return CH_NEWLINE;
            1: return CH_RETURN;
            2: return CH_BACK;
            default: return CHAR_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_random_command();
        int               roll;
        logic [CMD_W-1:0] op;
        roll = $urandom_range(0, 99);
        if (roll < 46)
            op = CMD_PUT;
        else if (roll < 58)
            op = CMD_ERASE;
        else if (roll < 70)
            op = CMD_WRITE_AT;
        else if (roll < 80)
            op = CMD_SET_CURSOR;
        else if (roll < 96)
            op = CMD_READ;
        else if (roll < 97)
            op = CMD_SPARE_A;
        else if (roll < 98)
            op = CMD_SPARE_B;
        else if (roll < 99)
            op = CMD_CLEAR;
        else
            op = CMD_PUT;
        send_command(op, pick_char(), pick_column(), pick_line());
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset geometry (80 x 30): every command and the cursor corner cases.
    task automatic test_default_console();
        drain();
        send_command(CMD_READ, 8'h00, 7'd0, 6'd0);
        send_command(CMD_READ, 8'h00, 7'd127, 6'd63);     // outside usable area, reset blank
        send_command(CMD_WRITE_AT, 8'h41, 7'd3, 6'd2);
        send_command(CMD_WRITE_AT, 8'hFF, 7'd127, 6'd63); // outside, dropped
        send_command(CMD_READ, 8'h00, 7'd3, 6'd2);
        send_command(CMD_SET_CURSOR, 8'h00, 7'd127, 6'd63); // clamps to the last cell
        send_command(CMD_PUT, 8'hFF, 7'd0, 6'd0);          // last cell: wrap and scroll
        send_command(CMD_PUT, 8'h00, 7'd0, 6'd0);          // NUL prints
        send_command(CMD_PUT, CH_BACK, 7'd0, 6'd0);
        send_command(CMD_PUT, CH_BACK, 7'd0, 6'd0);        // column 0: up one row
        send_command(CMD_PUT, CH_RETURN, 7'd0, 6'd0);
        send_command(CMD_PUT, CH_NEWLINE, 7'd0, 6'd0);
        send_command(CMD_PUT, CH_NEWLINE, 7'd0, 6'd0);     // bottom row: scroll
        send_command(CMD_SET_CURSOR, 8'h00, 7'd0, 6'd0);
        send_command(CMD_PUT, CH_BACK, 7'd0, 6'd0);        // origin: hold
        send_command(CMD_ERASE, 8'h00, 7'd0, 6'd0);        // origin: nothing happens
        send_command(CMD_SET_CURSOR, 8'h00, 7'd0, 6'd1);
        send_command(CMD_ERASE, 8'h00, 7'd0, 6'd0);        // erase across a row boundary
        send_command(CMD_SPARE_A, 8'hA5, 7'd85, 6'd42);
        send_command(CMD_SPARE_B, 8'h5A, 7'd42, 6'd21);
        send_command(CMD_CLEAR, 8'h00, 7'd0, 6'd0);
    endtask

    // Shrink the area under a cursor that sits far outside it.
    task automatic test_cursor_outside_area();
        set_geometry(8'd128, 8'd64, 8'hA5);
        send_command(CMD_SET_CURSOR, 8'h00, 7'd127, 6'd63);
        send_command(CMD_PUT, 8'h5A, 7'd0, 6'd0);          // full-size scroll
        send_command(CMD_WRITE_AT, 8'h77, 7'd120, 6'd60);
        send_command(CMD_SET_CURSOR, 8'h00, 7'd120, 6'd60);
        set_geometry(8'd5, 8'd4, 8'h5A);
        send_command(CMD_READ, 8'h00, 7'd120, 6'd60);      // held value outside the area
        send_command(CMD_SPARE_A, 8'h00, 7'd0, 6'd0);      // reports the stranded cursor
        send_command(CMD_PUT, 8'h41, 7'd0, 6'd0);          // dropped write, cursor still moves
        send_command(CMD_WRITE_AT, 8'h42, 7'd4, 6'd3);
        send_command(CMD_WRITE_AT, 8'h43, 7'd5, 6'd3);
        send_command(CMD_SET_CURSOR, 8'h00, 7'd127, 6'd63);
        set_geometry(8'd2, 8'd1, 8'h3C);
        send_command(CMD_PUT, CH_BACK, 7'd0, 6'd0);
        send_command(CMD_ERASE, 8'h00, 7'd0, 6'd0);        // blank lands outside, dropped
        send_command(CMD_PUT, CH_RETURN, 7'd0, 6'd0);
        send_command(CMD_PUT, CH_NEWLINE, 7'd0, 6'd0);
        send_command(CMD_READ, 8'h00, 7'd4, 6'd3);
    endtask

    // Random traffic over a sequence of geometries, extremes first, then
    // small random areas so scrolls stay cheap.
    task automatic test_random_traffic();
        int phase;
        int n;
        int items;
        for (phase = 0; phase < 12; phase++)
        begin
            case (phase)
                0: set_geometry(8'd0, 8'd0, 8'h00);
                1: set_geometry(8'd255, 8'd1, CFG_W'($urandom_range(0, 255)));
                2: set_geometry(8'd1, 8'hFF, CFG_W'($urandom_range(0, 255)));
                3: set_geometry(8'd128, 8'd64, 8'hFF);
                default: set_geometry(CFG_W'($urandom_range(1, 24)),
                                      CFG_W'($urandom_range(1, 12)),
                                      CFG_W'($urandom_range(0, 255)));
            endcase
            if (phase == 3)
                items = 40;
            else if (phase < 3)
                items = 80;
            else
                items = 65;
            for (n = 0; n < items; n++)
            begin
                // Alternate stretches of back-to-back beats and random gaps.
                if (n % 20 == 0)
                    gap_max = ($urandom_range(0, 2) == 0) ? 0 : 7;
                send_random_command();
            end
        end
    endtask

    initial
    begin
        blank_screen();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_default_console();
        test_cursor_outside_area();
        test_random_traffic();

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
